// ===== rtl/core/tlbmmu_pkg.sv =====
// ============================================================================
// Two-level page translation TLB package
// Shared constants, payload structs, status codes and the control interface
// between the controller and the datapath.
// ============================================================================
package tlbmmu_pkg;

    localparam int OFFSET_BITS    = 12;
    localparam int INNER_BITS     = 10;
    localparam int TLB_ENTRIES    = 16;
    localparam int LEAF_DEPTH     = 4096;
    localparam int FRAME_BITS     = 14;

    localparam int VA_BITS        = 32;
    localparam int DIR_BITS       = VA_BITS - OFFSET_BITS - INNER_BITS;
    localparam int DIR_DEPTH      = 1 << DIR_BITS;
    localparam int TAG_BITS       = VA_BITS - OFFSET_BITS;
    localparam int TBLK_BITS      = 10;
    localparam int FRAME_IN_BITS  = 14;
    localparam int PA_BITS        = 26;
    localparam int CNT_BITS       = 32;
    localparam int LFSR_BITS      = 16;
    localparam int TLB_IDX_BITS   = $clog2(TLB_ENTRIES);
    localparam int LEAF_ADDR_BITS = $clog2(LEAF_DEPTH);
    localparam int LADDR_BITS     = TBLK_BITS + INNER_BITS;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MAPPED    = 2'd1,
        ST_FAULT     = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic {
        MODE_TRANSLATE = 1'b0,
        MODE_MAP       = 1'b1
    } mode_t;

    typedef struct packed {
        logic                     mode;
        logic [VA_BITS-1:0]       virtual_address;
        logic [TBLK_BITS-1:0]     table_block;
        logic [FRAME_IN_BITS-1:0] frame;
    } in_t;

    typedef struct packed {
        logic [PA_BITS-1:0]  physical_address;
        logic                tlb_hit;
        logic [1:0]          status;
        logic [CNT_BITS-1:0] hit_count;
        logic [CNT_BITS-1:0] miss_count;
    } out_t;

    typedef struct packed {
        logic                 valid;
        logic [TBLK_BITS-1:0] blk;
    } dir_entry_t;

    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] frame;
    } leaf_entry_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic dir_step;
        logic leaf_step;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } stat_t;

endpackage

// ===== rtl/core/tlbmmu_ctrl.sv =====
// ============================================================================
// Translation controller
// Sequences the clearing pass and the three steps of each item.
// ============================================================================
module tlbmmu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tlbmmu_pkg::stat_t  stat,
    output tlbmmu_pkg::cmd_t   cmd,
    output logic               busy
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_LEAF
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:   state_next = S_LEAF;
            S_LEAF:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy          = busy_reg;
    assign cmd.clear     = (state_reg == S_CLEAR);
    assign cmd.load      = (state_reg == S_IDLE) && start;
    assign cmd.dir_step  = (state_reg == S_DIR);
    assign cmd.leaf_step = (state_reg == S_LEAF);

endmodule

// ===== rtl/core/tlbmmu_dp.sv =====
// ============================================================================
// Translation datapath
// TLB registers, directory and leaf memories, counters and the result register.
// ============================================================================
module tlbmmu_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  tlbmmu_pkg::cmd_t   cmd,
    input  tlbmmu_pkg::in_t    request,
    output tlbmmu_pkg::stat_t  stat,
    output logic               done,
    output tlbmmu_pkg::out_t   result
);

    localparam int OFF = tlbmmu_pkg::OFFSET_BITS;
    localparam int INB = tlbmmu_pkg::INNER_BITS;

    // Memories.
    tlbmmu_pkg::dir_entry_t  dir_mem  [tlbmmu_pkg::DIR_DEPTH];
    tlbmmu_pkg::leaf_entry_t leaf_mem [tlbmmu_pkg::LEAF_DEPTH];

    // TLB.
    logic [tlbmmu_pkg::TAG_BITS-1:0]   tlb_tag_reg   [tlbmmu_pkg::TLB_ENTRIES];
    logic [tlbmmu_pkg::FRAME_BITS-1:0] tlb_frame_reg [tlbmmu_pkg::TLB_ENTRIES];
    logic [tlbmmu_pkg::TLB_ENTRIES-1:0] tlb_valid_reg;

    logic [tlbmmu_pkg::LFSR_BITS-1:0]      lfsr_reg;
    logic [tlbmmu_pkg::CNT_BITS-1:0]       hits_reg;
    logic [tlbmmu_pkg::CNT_BITS-1:0]       misses_reg;
    logic [tlbmmu_pkg::LEAF_ADDR_BITS-1:0] clr_cnt_reg;

    tlbmmu_pkg::in_t         req_reg;
    tlbmmu_pkg::dir_entry_t  dir_rd_reg;
    tlbmmu_pkg::leaf_entry_t leaf_rd_reg;
    logic                    hit_reg;
    logic [tlbmmu_pkg::FRAME_BITS-1:0] hit_frame_reg;
    logic                    in_range_reg;
    logic                    done_reg;
    tlbmmu_pkg::out_t        result_reg;

    logic [tlbmmu_pkg::TAG_BITS-1:0]   tag;
    logic [tlbmmu_pkg::DIR_BITS-1:0]   dir_idx_in;
    logic [INB-1:0]                    leaf_idx;
    logic [OFF-1:0]                    offset;

    logic                              hit;
    logic [tlbmmu_pkg::FRAME_BITS-1:0] hit_frame;
    logic                              has_free;
    logic [tlbmmu_pkg::TLB_IDX_BITS-1:0] free_idx;

    logic                              dir_write;
    logic [tlbmmu_pkg::TBLK_BITS-1:0]  blk;
    logic [tlbmmu_pkg::LADDR_BITS-1:0] laddr;

    logic                              fill;
    logic [tlbmmu_pkg::FRAME_BITS-1:0] fill_frame;
    logic [tlbmmu_pkg::TLB_IDX_BITS-1:0] fill_idx;
    logic                              leaf_write;
    logic                              hit_inc;
    logic                              miss_inc;
    tlbmmu_pkg::out_t                  res;
    logic [tlbmmu_pkg::FRAME_BITS-1:0] pa_frame;
    logic                              lfsr_fb;

    assign tag        = req_reg.virtual_address[tlbmmu_pkg::VA_BITS-1:OFF];
    assign dir_idx_in = request.virtual_address[tlbmmu_pkg::VA_BITS-1:OFF+INB];
    assign leaf_idx   = req_reg.virtual_address[OFF+INB-1:OFF];
    assign offset     = req_reg.virtual_address[OFF-1:0];

    // Parallel tag compare; the lowest matching entry wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_frame = '0;
        has_free  = 1'b0;
        free_idx  = '0;
        for (int i = tlbmmu_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_tag_reg[i] == tag))
            begin
                hit       = 1'b1;
                hit_frame = tlb_frame_reg[i];
            end
            if (!tlb_valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = tlbmmu_pkg::TLB_IDX_BITS'(i);
            end
        end
    end

    // Directory step: pick the leaf block, setting it first on a map.
    always_comb
    begin
        dir_write = cmd.dir_step && (req_reg.mode == tlbmmu_pkg::MODE_MAP)
                    && !dir_rd_reg.valid;
        if (dir_rd_reg.valid)
        begin
            blk = dir_rd_reg.blk;
        end
        else if (req_reg.mode == tlbmmu_pkg::MODE_MAP)
        begin
            blk = req_reg.table_block;
        end
        else
        begin
            blk = '0;
        end
        laddr = {blk, leaf_idx};
    end

    // Leaf step: decide the result and the updates.
    always_comb
    begin
        fill       = 1'b0;
        fill_frame = leaf_rd_reg.frame;
        leaf_write = 1'b0;
        hit_inc    = 1'b0;
        miss_inc   = 1'b0;
        pa_frame   = '0;
        res        = '0;
        res.status = tlbmmu_pkg::ST_OK;
        if (req_reg.mode == tlbmmu_pkg::MODE_TRANSLATE)
        begin
            if (hit_reg)
            begin
                hit_inc     = 1'b1;
                res.tlb_hit = 1'b1;
                pa_frame    = hit_frame_reg;
            end
            else
            begin
                miss_inc = 1'b1;
                if (!in_range_reg)
                begin
                    res.status = tlbmmu_pkg::ST_RANGE;
                end
                else if (leaf_rd_reg.valid)
                begin
                    fill     = 1'b1;
                    pa_frame = leaf_rd_reg.frame;
                end
                else
                begin
                    res.status = tlbmmu_pkg::ST_FAULT;
                end
            end
        end
        else
        begin
            fill_frame = req_reg.frame[tlbmmu_pkg::FRAME_BITS-1:0];
            if (!in_range_reg)
            begin
                res.status = tlbmmu_pkg::ST_RANGE;
            end
            else if (leaf_rd_reg.valid)
            begin
                res.status = tlbmmu_pkg::ST_MAPPED;
            end
            else
            begin
                leaf_write = 1'b1;
                miss_inc   = 1'b1;
                fill       = 1'b1;
                pa_frame   = fill_frame;
            end
        end
        if ((res.status == tlbmmu_pkg::ST_OK))
        begin
            res.physical_address =
                tlbmmu_pkg::PA_BITS'({pa_frame, offset});
        end
        res.hit_count  = (hit_inc && (hits_reg != '1)) ? hits_reg + 1'b1 : hits_reg;
        res.miss_count = (miss_inc && (misses_reg != '1)) ? misses_reg + 1'b1
                                                           : misses_reg;
        fill_idx = has_free ? free_idx : lfsr_reg[tlbmmu_pkg::TLB_IDX_BITS-1:0];
    end

    assign lfsr_fb = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];

    // Directory memory.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            dir_mem[clr_cnt_reg[tlbmmu_pkg::DIR_BITS-1:0]] <= '0;
        end
        else if (dir_write)
        begin
            dir_mem[req_reg.virtual_address[tlbmmu_pkg::VA_BITS-1:OFF+INB]] <=
                {1'b1, req_reg.table_block};
        end
        if (cmd.load)
        begin
            dir_rd_reg <= dir_mem[dir_idx_in];
        end
    end

    // Leaf memory.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            leaf_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.leaf_step && leaf_write)
        begin
            leaf_mem[laddr[tlbmmu_pkg::LEAF_ADDR_BITS-1:0]] <= {1'b1, fill_frame};
        end
        if (cmd.dir_step)
        begin
            leaf_rd_reg <= leaf_mem[laddr[tlbmmu_pkg::LEAF_ADDR_BITS-1:0]];
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.dir_step)
        begin
            hit_reg       <= hit;
            hit_frame_reg <= hit_frame;
            in_range_reg  <= (laddr < tlbmmu_pkg::LADDR_BITS'(tlbmmu_pkg::LEAF_DEPTH));
        end
        if (cmd.leaf_step)
        begin
            result_reg <= res;
        end
        if (cmd.leaf_step && fill)
        begin
            tlb_tag_reg[fill_idx]   <= tag;
            tlb_frame_reg[fill_idx] <= fill_frame;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg <= '0;
            lfsr_reg      <= tlbmmu_pkg::LFSR_BITS'(1);
            hits_reg      <= '0;
            misses_reg    <= '0;
            clr_cnt_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.leaf_step;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.leaf_step)
            begin
                hits_reg   <= res.hit_count;
                misses_reg <= res.miss_count;
                if (fill)
                begin
                    tlb_valid_reg[fill_idx] <= 1'b1;
                    if (!has_free)
                    begin
                        lfsr_reg <= {lfsr_fb, lfsr_reg[tlbmmu_pkg::LFSR_BITS-1:1]};
                    end
                end
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg ==
                              tlbmmu_pkg::LEAF_ADDR_BITS'(tlbmmu_pkg::LEAF_DEPTH - 1));
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/two_level_page_translation_tlb.sv =====
// ============================================================================
// Two-level page translation unit with TLB
// Translates or maps one virtual address per item over a directory and a
// leaf table, caching translations in a fully associative TLB.
// ============================================================================
// Flow: an accepted item is registered, then the directory read and the leaf
// read run in turn, and its result is registered with done high; busy is low
// again in that same cycle, so a new item is taken only once the last is done.
// Reset: busy stays high for a clearing pass over every leaf address that zeroes
// the directory and leaf memories; the TLB and the counters clear at once, the LFSR is set to one.
// The receiver cannot stall: done is high for exactly one cycle with each result.
module two_level_page_translation_tlb (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tlbmmu_pkg::in_t   request,
    output logic              done,
    output tlbmmu_pkg::out_t  result
);

    // The controller steps through the directory read and the leaf read; the
    // datapath holds the TLB, the two table memories and the counters.
    tlbmmu_pkg::cmd_t  cmd;
    tlbmmu_pkg::stat_t stat;

    tlbmmu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tlbmmu_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule
